// ===== rtl/aaf_pkg.sv =====
// Shared types and constants for the accumulator ALU and flag unit.
package aaf_pkg;

   // Operation codes. All sixteen codes of the field have a meaning.
   typedef enum logic [3:0] {
      FUNC_ADC     = 4'd0,
      FUNC_AND     = 4'd1,
      FUNC_ASL_MEM = 4'd2,
      FUNC_ASL_ACC = 4'd3,
      FUNC_BCC     = 4'd4,
      FUNC_BCS     = 4'd5,
      FUNC_BEQ     = 4'd6,
      FUNC_BMI     = 4'd7,
      FUNC_BNE     = 4'd8,
      FUNC_BPL     = 4'd9,
      FUNC_BVC     = 4'd10,
      FUNC_BVS     = 4'd11,
      FUNC_CLC     = 4'd12,
      FUNC_CLD     = 4'd13,
      FUNC_CLI     = 4'd14,
      FUNC_CLV     = 4'd15
   } func_type;

   // The six stored processor flags.
   typedef struct packed {
      logic n;
      logic v;
      logic d;
      logic i;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] operand;
   } req_type;

   typedef struct packed {
      logic [7:0] acc_out;
      logic [7:0] status_out;
      logic [7:0] mem_result;
      logic       mem_write;
      logic       branch_taken;
   } rsp_type;

   // BCD correction constants.
   localparam logic [4:0] BCD_DIGIT_LIMIT = 5'd10;
   localparam logic [3:0] BCD_DIGIT_FIX   = 4'd6;
   localparam logic [8:0] BCD_HIGH_LIMIT  = 9'h0A0;
   localparam logic [9:0] BCD_HIGH_FIX    = 10'h060;

endpackage

// ===== rtl/accumulator_alu_flag_unit.sv =====
// Top level of the accumulator ALU and flag unit: input register, state and result register.
//
// Usage: a request on the req_ channel carries an operation code and the
// operand byte already fetched from memory. For every accepted request the
// rsp_ channel returns exactly one result: the accumulator and status byte
// after the operation, the shifted memory byte with its write strobe, and
// whether a branch condition holds. Results leave in request order.
// A request accepted into the input register passes on to the result
// register, and so to rsp_data with rsp_valid high, at an edge at which the
// result register is empty or being read. Throughput is one request per
// cycle while rsp_ready stays high; the accumulator and flags are written at
// the same edge that loads the result register, so the next request in the
// input register always sees the state left by the one before it.
// Reset clears the accumulator, all flags and both valid bits; until an
// operation sets a flag, the status byte reads with only the constant-one
// bit set.
// When the receiver holds rsp_ready low, the result register keeps its
// request, the input register can still take one more, and req_ready falls
// only when both are full and the result is not being read. Nothing is
// dropped.
module accumulator_alu_flag_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aaf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aaf_pkg::rsp_type rsp_data
);
   import aaf_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   flags_type flags_ff;
   flags_type flags_in;
   rsp_type   alu_rsp;
   logic      advance;
   logic      req_fire;
   logic      s1_fire;

   // The result register can take a new result when it is empty or being read.
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign s1_fire  = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire = req_valid && req_ready;

   aaf_alu u_alu (
      .func       (s1_data_ff.func),
      .operand    (s1_data_ff.operand),
      .acc        (acc_ff),
      .flags      (flags_ff),
      .acc_next   (acc_in),
      .flags_next (flags_in),
      .rsp        (alu_rsp)
   );

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            acc_ff   <= acc_in;
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The input side stalls only when both registers hold a request.
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_ready low with a free register");

   // The accumulator moves only when a request passes into the result register.
   a_acc_stable: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(acc_ff) && $stable(flags_ff))
      else $error("state changed without a request");

   // A result without a write strobe carries a zero memory byte.
   a_mem_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.mem_write) |-> (rsp_data_ff.mem_result == 8'd0))
      else $error("memory byte without write strobe");

   // Decimal mode can only be cleared, never set.
   a_d_never_rises: assert property (@(posedge clock) disable iff (reset)
      !$rose(flags_ff.d))
      else $error("decimal flag was set");

endmodule

// ===== rtl/aaf_alu.sv =====
// Combinational ALU, branch test and flag update for one request.
module aaf_alu (
   input  aaf_pkg::func_type  func,
   input  logic [7:0]         operand,
   input  logic [7:0]         acc,
   input  aaf_pkg::flags_type flags,
   output logic [7:0]         acc_next,
   output aaf_pkg::flags_type flags_next,
   output aaf_pkg::rsp_type   rsp
);
   import aaf_pkg::*;

   logic [8:0] bin_sum;
   logic [4:0] lo_raw;
   logic [4:0] lo_adj;
   logic [8:0] dec_sum;
   logic [9:0] dec_signed;
   logic [9:0] dec_fixed;
   logic       dec_overflow;
   logic [7:0] shl_src;
   logic [7:0] shl_res;
   logic [7:0] and_res;
   logic [7:0] mem_res;
   logic       mem_wr;
   logic       br_taken;

   // Binary sum; its low byte also sets Z in decimal mode.
   assign bin_sum = {1'b0, acc} + {1'b0, operand} + {8'd0, flags.c};

   // Decimal mode: low digit with carry, corrected past nine.
   assign lo_raw = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, flags.c};
   assign lo_adj = (lo_raw >= BCD_DIGIT_LIMIT) ?
                   {1'b1, lo_raw[3:0] + BCD_DIGIT_FIX} : lo_raw;
   assign dec_sum = {1'b0, acc[7:4], 4'd0} + {1'b0, operand[7:4], 4'd0}
                  + {4'd0, lo_adj};

   // High nibbles taken as signed; V is set when the sum leaves -128..127.
   assign dec_signed = {{2{acc[7]}}, acc[7:4], 4'd0}
                     + {{2{operand[7]}}, operand[7:4], 4'd0}
                     + {5'd0, lo_adj};
   assign dec_overflow = !((dec_signed[9] == dec_signed[8]) &&
                           (dec_signed[8] == dec_signed[7]));
   assign dec_fixed = (dec_sum >= BCD_HIGH_LIMIT) ?
                      {1'b0, dec_sum} + BCD_HIGH_FIX : {1'b0, dec_sum};

   assign shl_src = (func == FUNC_ASL_MEM) ? operand : acc;
   assign shl_res = {shl_src[6:0], 1'b0};
   assign and_res = acc & operand;

   always_comb begin
      acc_next   = acc;
      flags_next = flags;
      mem_res    = 8'd0;
      mem_wr     = 1'b0;
      br_taken   = 1'b0;
      unique case (func)
         FUNC_ADC: begin
            flags_next.z = (bin_sum[7:0] == 8'd0);
            if (flags.d) begin
               flags_next.n = dec_sum[7];
               flags_next.v = dec_overflow;
               flags_next.c = |dec_fixed[9:8];
               acc_next     = dec_fixed[7:0];
            end else begin
               flags_next.n = bin_sum[7];
               flags_next.v = !(acc[7] ^ operand[7]) && (acc[7] ^ bin_sum[7]);
               flags_next.c = bin_sum[8];
               acc_next     = bin_sum[7:0];
            end
         end
         FUNC_AND: begin
            acc_next     = and_res;
            flags_next.n = and_res[7];
            flags_next.z = (and_res == 8'd0);
         end
         FUNC_ASL_MEM: begin
            mem_res      = shl_res;
            mem_wr       = 1'b1;
            flags_next.c = shl_src[7];
            flags_next.n = shl_res[7];
            flags_next.z = (shl_res == 8'd0);
         end
         FUNC_ASL_ACC: begin
            acc_next     = shl_res;
            flags_next.c = shl_src[7];
            flags_next.n = shl_res[7];
            flags_next.z = (shl_res == 8'd0);
         end
         FUNC_BCC: br_taken = !flags.c;
         FUNC_BCS: br_taken = flags.c;
         FUNC_BEQ: br_taken = flags.z;
         FUNC_BMI: br_taken = flags.n;
         FUNC_BNE: br_taken = !flags.z;
         FUNC_BPL: br_taken = !flags.n;
         FUNC_BVC: br_taken = !flags.v;
         FUNC_BVS: br_taken = flags.v;
         FUNC_CLC: flags_next.c = 1'b0;
         FUNC_CLD: flags_next.d = 1'b0;
         FUNC_CLI: flags_next.i = 1'b0;
         FUNC_CLV: flags_next.v = 1'b0;
      endcase
   end

   always_comb begin
      rsp.acc_out      = acc_next;
      rsp.status_out   = {flags_next.n, flags_next.v, 1'b1, 1'b0,
                          flags_next.d, flags_next.i, flags_next.z, flags_next.c};
      rsp.mem_result   = mem_res;
      rsp.mem_write    = mem_wr;
      rsp.branch_taken = br_taken;
   end

endmodule
